// ----- sv/sliding_time_window_evaluator_core_assert.svh -----
// Assertion macros for the sliding time window evaluator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SLIDING_TIME_WINDOW_EVALUATOR_CORE_ASSERT_SVH
`define SLIDING_TIME_WINDOW_EVALUATOR_CORE_ASSERT_SVH

// Checked only while out of reset.
`define STWE_ASSERT_RUN(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, also during reset.
`define STWE_ASSERT_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/stwe_pkg.sv -----
// Shared types and constants of the sliding time window evaluator.
// No dependencies.
package stwe_pkg;

	localparam int STWE_MAX_POINTS = 64;
	localparam int STWE_MERGE_COUNT_BITS = 16;

	localparam int VALUE_W = 32;
	localparam int TIME_W = 48;
	localparam int CFG_W = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BIN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE = 2'd2;

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_TWA = 2'd1;
	localparam logic [1:0] MODE_MAX = 2'd2;

	localparam logic [CFG_W-1:0] WINDOW_RESET = 32'd300000000;
	localparam logic [CFG_W-1:0] BIN_RESET = 32'd10000000;
	localparam logic [1:0] MODE_RESET = MODE_TWA;

	localparam int DIV_NUM_W = 66;
	localparam int DIV_DEN_W = 33;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [TIME_W-1:0] time_us;
	} sample_t;

endpackage

// ----- sv/sliding_time_window_evaluator_core.sv -----
// One beat is processed at a time: purge of expired points, then merge into the newest point
// or append, then evaluation over the stored points, with a serial division in the mean modes
// and for a merge. A new sample is taken from the queue only once the previous beat has been
// written to the result register.
// Asynchronous active-low reset empties the store and loads the register defaults.
`include "sliding_time_window_evaluator_core_assert.svh"
module sliding_time_window_evaluator_core import stwe_pkg::*; #(
	parameter int MAX_POINTS = STWE_MAX_POINTS,
	parameter int MERGE_COUNT_BITS = STWE_MERGE_COUNT_BITS,
	parameter int CNT_W = $clog2(MAX_POINTS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [REG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic push,
	output logic full,
	input logic signed [VALUE_W-1:0] sample_value,
	input logic [TIME_W-1:0] sample_time_us,
	output logic empty,
	input logic pop,
	output logic signed [VALUE_W-1:0] filtered_value,
	output logic [CNT_W-1:0] point_count,
	output logic overflow
);

	sample_t in_sample;
	sample_t q_sample;
	logic q_valid;
	logic q_take;

	assign in_sample.value = sample_value;
	assign in_sample.time_us = sample_time_us;

	stwe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_sample(in_sample),
		.out_valid(q_valid),
		.take(q_take),
		.out_sample(q_sample)
	);

	stwe_back #(
		.MAX_POINTS(MAX_POINTS),
		.MERGE_COUNT_BITS(MERGE_COUNT_BITS),
		.IDX_W($clog2(MAX_POINTS)),
		.CNT_W(CNT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(q_valid),
		.in_take(q_take),
		.in_sample(q_sample),
		.empty(empty),
		.pop(pop),
		.filtered_value(filtered_value),
		.point_count(point_count),
		.overflow(overflow)
	);

	`STWE_ASSERT_RUN(a_count_bound, point_count <= CNT_W'(MAX_POINTS), "point count above store size")
	`STWE_ASSERT_RUN(a_result_has_point, !empty |-> point_count != '0, "result with empty store")
	`STWE_ASSERT_RUN(a_overflow_full, !empty && overflow |-> point_count == CNT_W'(MAX_POINTS), "overflow with store not full")

endmodule

// ----- sv/stwe_front.sv -----
// Input side of the evaluator: a two-entry sample queue.
// Depends on stwe_pkg.
module stwe_front import stwe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input sample_t in_sample,
	output logic out_valid,
	input logic take,
	output sample_t out_sample
);

	sample_t buf_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_take;

	assign full = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_sample = buf_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_take = take && out_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!do_push && do_take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- sv/stwe_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on stwe_pkg for the default operand widths.
module stwe_div import stwe_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W,
	parameter int DEN_W = DIV_DEN_W
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic done,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] sh;
	logic [DEN_W:0] diff;
	logic fits;

	assign sh = {rem_q, quot_q[NUM_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign fits = (sh >= {1'b0, den_q});
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quot_q <= num;
				rem_q <= '0;
				den_q <= den;
				cnt_q <= CW'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
				quot_q <= {quot_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/stwe_back.sv -----
// Processing side of the evaluator: point store, purge, merge or append,
// window evaluation and the result register. Depends on stwe_pkg, stwe_div.
module stwe_back import stwe_pkg::*; #(
	parameter int MAX_POINTS = STWE_MAX_POINTS,
	parameter int MERGE_COUNT_BITS = STWE_MERGE_COUNT_BITS,
	parameter int IDX_W = $clog2(MAX_POINTS),
	parameter int CNT_W = $clog2(MAX_POINTS + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [REG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_take,
	input sample_t in_sample,
	output logic empty,
	input logic pop,
	output logic signed [VALUE_W-1:0] filtered_value,
	output logic [CNT_W-1:0] point_count,
	output logic overflow
);

	localparam int MCB = MERGE_COUNT_BITS;
	localparam int MM_W = VALUE_W + MCB + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PURGE_RD = 4'd1;
	localparam logic [3:0] ST_PURGE_CK = 4'd2;
	localparam logic [3:0] ST_DECIDE = 4'd3;
	localparam logic [3:0] ST_MERGE_GO = 4'd4;
	localparam logic [3:0] ST_MERGE_WAIT = 4'd5;
	localparam logic [3:0] ST_EV_START = 4'd6;
	localparam logic [3:0] ST_EV_RUN = 4'd7;
	localparam logic [3:0] ST_EV_DIV = 4'd8;
	localparam logic [3:0] ST_EV_WAIT = 4'd9;
	localparam logic [3:0] ST_OUT = 4'd10;

	function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(MAX_POINTS)) begin
			s = s - (CNT_W+1)'(MAX_POINTS);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] h);
		return (h == IDX_W'(MAX_POINTS - 1)) ? '0 : h + IDX_W'(1);
	endfunction

	function automatic logic [VALUE_W-1:0] round_fix(input logic [DIV_NUM_W-1:0] q,
			input logic neg);
		logic [VALUE_W:0] qc;
		logic [VALUE_W:0] nq;
		qc = (q > DIV_NUM_W'(33'h1_0000_0000 >> 1)) ? 33'h1_0000_0000 >> 1
			: q[VALUE_W:0];
		nq = ~qc + 33'd1;
		if (neg) begin
			return nq[VALUE_W-1:0];
		end else if (qc[VALUE_W-1] || qc[VALUE_W]) begin
			return 32'h7FFF_FFFF;
		end else begin
			return qc[VALUE_W-1:0];
		end
	endfunction

	logic [CFG_W-1:0] window_q;
	logic [CFG_W-1:0] bin_q;
	logic [1:0] mode_q;

	logic [3:0] st_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [MCB-1:0] mc_q;
	logic signed [VALUE_W-1:0] newest_v_q;
	logic [TIME_W-1:0] newest_t_q;
	logic signed [VALUE_W-1:0] v_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] limit_q;
	logic ovf_q;
	logic signed [DIV_NUM_W-1:0] mul_q;
	logic neg_q;

	logic [IDX_W-1:0] ptr_q;
	logic [CNT_W-1:0] k_q;
	logic vld_s1;
	logic first_s1;
	logic signed [VALUE_W-1:0] rd_val_s1;
	logic [TIME_W-1:0] rd_time_s1;
	logic [TIME_W-1:0] prev_q;
	logic vld_s2;
	logic signed [DIV_NUM_W-1:0] prod_s2;
	logic signed [DIV_NUM_W-1:0] acc_q;
	logic signed [VALUE_W-1:0] max_q;

	logic out_vld_q;
	logic signed [VALUE_W-1:0] out_val_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic out_ovf_q;
	logic signed [VALUE_W-1:0] res_q;

	logic signed [VALUE_W-1:0] val_mem [MAX_POINTS];
	logic [TIME_W-1:0] time_mem [MAX_POINTS];
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic signed [VALUE_W-1:0] wr_val;
	logic [IDX_W-1:0] rd_addr;

	logic [TIME_W-1:0] t_in;
	logic [TIME_W-1:0] now_in;
	logic merge_hit;
	logic full_store;
	logic [IDX_W-1:0] head_a;
	logic [CNT_W-1:0] cnt_a;
	logic [IDX_W-1:0] newest_slot;
	logic issue;
	logic is_max;
	logic is_twa;
	logic [TIME_W:0] w_first;
	logic [TIME_W-1:0] w_next;
	logic [VALUE_W-1:0] w;
	logic signed [2*VALUE_W:0] wmul;
	logic signed [MM_W-1:0] mmul;
	logic signed [DIV_NUM_W-1:0] dnum_s;
	logic [DIV_NUM_W-1:0] dmag;
	logic [DIV_DEN_W-1:0] dden;
	logic [DIV_NUM_W-1:0] div_num;
	logic div_start;
	logic div_done;
	logic [DIV_NUM_W-1:0] div_quot;
	logic [VALUE_W-1:0] div_res;

	assign is_max = (mode_q == MODE_MAX);
	assign is_twa = (mode_q == MODE_TWA);

	assign t_in = in_sample.time_us;
	assign now_in = (count_q != '0 && t_in < newest_t_q) ? newest_t_q : t_in;
	assign in_take = (st_q == ST_IDLE) && in_valid;

	assign merge_hit = (count_q != '0)
		&& ((now_q - newest_t_q) < TIME_W'(bin_q));
	assign full_store = (count_q == CNT_W'(MAX_POINTS));
	assign head_a = full_store ? next_slot(head_q) : head_q;
	assign cnt_a = full_store ? count_q - CNT_W'(1) : count_q;
	assign newest_slot = slot_at(head_q, count_q - CNT_W'(1));

	assign issue = (st_q == ST_EV_RUN) && (k_q != count_q);
	assign rd_addr = (st_q == ST_EV_RUN) ? ptr_q : head_q;

	assign w_first = {1'b0, rd_time_s1} + (TIME_W+1)'(window_q) - {1'b0, now_q};
	assign w_next = rd_time_s1 - prev_q;
	assign w = first_s1 ? w_first[VALUE_W-1:0] : w_next[VALUE_W-1:0];
	assign wmul = $signed(rd_val_s1) * $signed({1'b0, w});
	assign mmul = $signed(newest_v_q) * $signed({1'b0, mc_q});

	always_comb begin
		if (st_q == ST_MERGE_GO) begin
			dnum_s = mul_q + DIV_NUM_W'(v_q);
			dden = DIV_DEN_W'(mc_q) + DIV_DEN_W'(1);
		end else begin
			dnum_s = acc_q;
			dden = is_twa ? DIV_DEN_W'(window_q) : DIV_DEN_W'(count_q);
		end
	end

	assign dmag = dnum_s[DIV_NUM_W-1] ? -dnum_s : dnum_s;
	assign div_num = dmag + DIV_NUM_W'(dden >> 1);
	assign div_start = (st_q == ST_MERGE_GO)
		|| (st_q == ST_EV_DIV && !is_max && dden != '0);
	assign div_res = round_fix(div_quot, neg_q);

	stwe_div #(
		.NUM_W(DIV_NUM_W),
		.DEN_W(DIV_DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(dden),
		.done(div_done),
		.quot(div_quot)
	);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = slot_at(head_a, cnt_a);
		wr_val = v_q;
		if (st_q == ST_DECIDE && !merge_hit) begin
			wr_en = 1'b1;
		end else if (st_q == ST_MERGE_WAIT && div_done) begin
			wr_en = 1'b1;
			wr_addr = newest_slot;
			wr_val = div_res;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_mem[wr_addr] <= wr_val;
			time_mem[wr_addr] <= now_q;
		end
		rd_val_s1 <= val_mem[rd_addr];
		rd_time_s1 <= time_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			bin_q <= BIN_RESET;
			mode_q <= MODE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW: window_q <= cfg_wdata;
				REG_BIN: bin_q <= cfg_wdata;
				REG_MODE: mode_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			mc_q <= '0;
			newest_v_q <= '0;
			newest_t_q <= '0;
			v_q <= '0;
			now_q <= '0;
			limit_q <= '0;
			ovf_q <= 1'b0;
			mul_q <= '0;
			neg_q <= 1'b0;
			ptr_q <= '0;
			k_q <= '0;
			vld_s1 <= 1'b0;
			first_s1 <= 1'b0;
			prev_q <= '0;
			vld_s2 <= 1'b0;
			prod_s2 <= '0;
			acc_q <= '0;
			max_q <= '0;
			res_q <= '0;
			out_vld_q <= 1'b0;
			out_val_q <= '0;
			out_cnt_q <= '0;
			out_ovf_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			first_s1 <= issue && (k_q == '0);
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				prev_q <= rd_time_s1;
				prod_s2 <= is_twa ? {wmul[2*VALUE_W], wmul} : DIV_NUM_W'(rd_val_s1);
				if (first_s1 || rd_val_s1 > max_q) begin
					max_q <= rd_val_s1;
				end
			end
			if (vld_s2) begin
				acc_q <= acc_q + prod_s2;
			end
			if (pop && out_vld_q && st_q != ST_OUT) begin
				out_vld_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q <= in_sample.value;
						now_q <= now_in;
						limit_q <= now_in - TIME_W'(window_q);
						ovf_q <= 1'b0;
						st_q <= (count_q != '0 && now_in >= TIME_W'(window_q))
							? ST_PURGE_RD : ST_DECIDE;
					end
				end
				ST_PURGE_RD: begin
					st_q <= ST_PURGE_CK;
				end
				ST_PURGE_CK: begin
					if (rd_time_s1 < limit_q) begin
						head_q <= next_slot(head_q);
						count_q <= count_q - CNT_W'(1);
						st_q <= (count_q == CNT_W'(1)) ? ST_DECIDE : ST_PURGE_RD;
					end else begin
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (merge_hit) begin
						mul_q <= DIV_NUM_W'(mmul);
						st_q <= ST_MERGE_GO;
					end else begin
						head_q <= head_a;
						count_q <= cnt_a + CNT_W'(1);
						ovf_q <= full_store;
						newest_v_q <= v_q;
						newest_t_q <= now_q;
						mc_q <= MCB'(1);
						st_q <= ST_EV_START;
					end
				end
				ST_MERGE_GO: begin
					neg_q <= dnum_s[DIV_NUM_W-1];
					st_q <= ST_MERGE_WAIT;
				end
				ST_MERGE_WAIT: begin
					if (div_done) begin
						newest_v_q <= div_res;
						newest_t_q <= now_q;
						if (mc_q != '1) begin
							mc_q <= mc_q + MCB'(1);
						end
						st_q <= ST_EV_START;
					end
				end
				ST_EV_START: begin
					ptr_q <= head_q;
					k_q <= '0;
					acc_q <= '0;
					max_q <= '0;
					st_q <= ST_EV_RUN;
				end
				ST_EV_RUN: begin
					if (issue) begin
						ptr_q <= next_slot(ptr_q);
						k_q <= k_q + CNT_W'(1);
					end else if (!vld_s1 && !vld_s2) begin
						st_q <= ST_EV_DIV;
					end
				end
				ST_EV_DIV: begin
					neg_q <= dnum_s[DIV_NUM_W-1];
					if (is_max) begin
						res_q <= max_q;
						st_q <= ST_OUT;
					end else if (dden == '0) begin
						res_q <= '0;
						st_q <= ST_OUT;
					end else begin
						st_q <= ST_EV_WAIT;
					end
				end
				ST_EV_WAIT: begin
					if (div_done) begin
						res_q <= div_res;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_vld_q || pop) begin
						out_vld_q <= 1'b1;
						out_val_q <= res_q;
						out_cnt_q <= count_q;
						out_ovf_q <= ovf_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign empty = !out_vld_q;
	assign filtered_value = out_val_q;
	assign point_count = out_cnt_q;
	assign overflow = out_ovf_q;

endmodule
